// ----- src/hid_keyboard_report_tracker_assert.svh -----
// assertion macros for the hid keyboard report tracker
// depends on a clock named clk and an active-low reset named rst_n in the using module
`ifndef HID_KEYBOARD_REPORT_TRACKER_ASSERT_SVH
`define HID_KEYBOARD_REPORT_TRACKER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define HKRT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hkrt assertion failed");
// next-cycle implication
`define HKRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hkrt assertion failed");
`else
`define HKRT_ASSERT_SAME(label, ante, cons)
`define HKRT_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ----- src/hkrt_pkg.sv -----
// shared types and constants for the hid keyboard report tracker
// no dependencies
package hkrt_pkg;

  typedef logic [7:0] hkrt_code_t;

  // request kinds
  localparam logic REQ_PRESS   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // modifier usage code range
  localparam hkrt_code_t MOD_FIRST = 8'hE0;
  localparam hkrt_code_t MOD_LAST  = 8'hE7;
  localparam hkrt_code_t CODE_NONE = 8'h00;

  // one key event as held in the input register
  typedef struct packed {
    logic       req_type;
    hkrt_code_t keycode;
  } hkrt_event_t;

endpackage

// ----- src/hid_keyboard_report_tracker.sv -----
// hid keyboard report tracker: an accepted event passes the input register, then the report
// registers and out_strobe; one event per cycle while busy is low, set by the input register
// and the slot update. the receiver cannot stall; busy is high only during synchronous reset
// and the cycle after. reset clears the modifier byte and empties all key slots.
// depends on hkrt_pkg, hkrt_report_update and hid_keyboard_report_tracker_assert.svh
module hid_keyboard_report_tracker #(
  parameter int SLOT_COUNT = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_req_type,
  input  hkrt_pkg::hkrt_code_t in_keycode,
  output logic                 out_strobe,
  output hkrt_pkg::hkrt_code_t out_modifier_byte,
  output hkrt_pkg::hkrt_code_t out_key_slot_0,
  output hkrt_pkg::hkrt_code_t out_key_slot_1,
  output hkrt_pkg::hkrt_code_t out_key_slot_2,
  output hkrt_pkg::hkrt_code_t out_key_slot_3,
  output hkrt_pkg::hkrt_code_t out_key_slot_4,
  output hkrt_pkg::hkrt_code_t out_key_slot_5
);
  import hkrt_pkg::*;
  `include "hid_keyboard_report_tracker_assert.svh"

  localparam int OUT_SLOTS = 6;

  logic                         busy_r;
  logic                         in_valid_r;
  hkrt_event_t                  ev_r;
  logic                         out_strobe_r;
  hkrt_code_t                   mod_r;
  hkrt_code_t                   mod_nxt;
  hkrt_code_t [SLOT_COUNT-1:0]  slots_r;
  hkrt_code_t [SLOT_COUNT-1:0]  slots_nxt;
  hkrt_code_t [OUT_SLOTS-1:0]   out_slots;

  // busy only around reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy = busy_r;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= start && !busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      ev_r.req_type <= in_req_type;
      ev_r.keycode  <= in_keycode;
    end
  end

  // next report
  hkrt_report_update #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_update (
    .ev        (ev_r),
    .mod_cur   (mod_r),
    .slots_cur (slots_r),
    .mod_nxt   (mod_nxt),
    .slots_nxt (slots_nxt)
  );

  // report state doubles as the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
      mod_r        <= CODE_NONE;
      slots_r      <= '0;
    end else begin
      out_strobe_r <= in_valid_r;
      if (in_valid_r) begin
        mod_r   <= mod_nxt;
        slots_r <= slots_nxt;
      end
    end
  end

  // map stored slots onto the six result ports
  generate
    for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_out
      if (j < SLOT_COUNT) begin : g_used
        assign out_slots[j] = slots_r[j];
      end else begin : g_unused
        assign out_slots[j] = CODE_NONE;
      end
    end
  endgenerate

  assign out_strobe        = out_strobe_r;
  assign out_modifier_byte = mod_r;
  assign out_key_slot_0    = out_slots[0];
  assign out_key_slot_1    = out_slots[1];
  assign out_key_slot_2    = out_slots[2];
  assign out_key_slot_3    = out_slots[3];
  assign out_key_slot_4    = out_slots[4];
  assign out_key_slot_5    = out_slots[5];

  // every result comes from an event held in the input register in the cycle before
  `HKRT_ASSERT_SAME(a_strobe_has_event, out_strobe_r, $past(in_valid_r))
  // every registered event produces a result
  `HKRT_ASSERT_NEXT(a_event_gives_strobe, in_valid_r, out_strobe_r)
  // a modifier event leaves the key slots alone
  `HKRT_ASSERT_NEXT(a_mod_keeps_slots,
    in_valid_r && (ev_r.keycode >= MOD_FIRST) && (ev_r.keycode <= MOD_LAST),
    $stable(slots_r))
  // the report only changes when a result is shown
  `HKRT_ASSERT_NEXT(a_report_changes_with_strobe, !in_valid_r,
    $stable(mod_r) && $stable(slots_r))

endmodule

// ----- src/hkrt_report_update.sv -----
// next-report logic: applies one key event to the modifier byte and key slots
// depends on hkrt_pkg
module hkrt_report_update #(
  parameter int SLOT_COUNT = 6
) (
  input  hkrt_pkg::hkrt_event_t                ev,
  input  hkrt_pkg::hkrt_code_t                 mod_cur,
  input  hkrt_pkg::hkrt_code_t [SLOT_COUNT-1:0] slots_cur,
  output hkrt_pkg::hkrt_code_t                 mod_nxt,
  output hkrt_pkg::hkrt_code_t [SLOT_COUNT-1:0] slots_nxt
);
  import hkrt_pkg::*;

  logic                  is_mod;
  logic                  code_zero;
  logic [7:0]            mod_bit;
  logic [SLOT_COUNT-1:0] hit;
  logic [SLOT_COUNT-1:0] empty;
  logic [SLOT_COUNT-1:0] wr_sel;
  logic                  any_hit;
  logic                  any_empty;
  logic                  upper_empty;

  assign is_mod    = (ev.keycode >= MOD_FIRST) && (ev.keycode <= MOD_LAST);
  assign code_zero = (ev.keycode == CODE_NONE);
  assign mod_bit   = 8'b1 << ev.keycode[2:0];

  // per-slot compares
  always_comb begin
    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit[i]   = (slots_cur[i] == ev.keycode);
      empty[i] = (slots_cur[i] == CODE_NONE);
    end
  end

  assign any_hit   = |hit;
  assign any_empty = |empty;

  // highest empty slot wins, slot 0 when full
  always_comb begin
    upper_empty = 1'b0;
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      wr_sel[i]   = empty[i] && !upper_empty;
      upper_empty = upper_empty || empty[i];
    end
    if (!any_empty) begin
      wr_sel[0] = 1'b1;
    end
  end

  // modifier byte
  always_comb begin
    mod_nxt = mod_cur;
    if (is_mod) begin
      if (ev.req_type == REQ_RELEASE) begin
        mod_nxt = mod_cur & ~mod_bit;
      end else begin
        mod_nxt = mod_cur | mod_bit;
      end
    end
  end

  // key slots
  always_comb begin
    slots_nxt = slots_cur;
    if (!is_mod && !code_zero) begin
      if (ev.req_type == REQ_RELEASE) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (hit[i]) begin
            slots_nxt[i] = CODE_NONE;
          end
        end
      end else if (!any_hit) begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (wr_sel[i]) begin
            slots_nxt[i] = ev.keycode;
          end
        end
      end
    end
  end

endmodule

// ----- dv/tb_hid_keyboard_report_tracker.sv -----
// testbench for hid_keyboard_report_tracker: directed and random key transfers,
// every report checked field by field against a predicted copy of the report
// depends on hkrt_pkg and the hid_keyboard_report_tracker rtl
`timescale 1ns / 1ps

module tb_hid_keyboard_report_tracker;
  import hkrt_pkg::*;

  localparam int SLOT_COUNT = 6;
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_PER_PHASE = 610;

  // one keyboard report as seen on the result ports
  typedef struct packed {
    hkrt_code_t       modifier;
    logic [5:0][7:0]  slot;
  } kbd_report_t;

  // predicted report state and the queue of reports still owed by the block
  class report_scoreboard;
    hkrt_code_t  mods = CODE_NONE;
    hkrt_code_t  held_keys [SLOT_COUNT];
    kbd_report_t owed_reports [$];
    int          errors = 0;

    function new();
      foreach (held_keys[i]) held_keys[i] = CODE_NONE;
    endfunction

    // update the held keys and modifiers for one accepted transfer
    function void note_event(logic req, hkrt_code_t code);
      kbd_report_t rep;
      hkrt_code_t  mask;
      int          pick;
      bit          already_held;
      pick = 0;
      already_held = 1'b0;
      if (code >= MOD_FIRST && code <= MOD_LAST) begin
        mask = 8'h01 << (code - MOD_FIRST);
        if (req == REQ_RELEASE) mods = mods & ~mask;
        else mods = mods | mask;
      end else if (code != CODE_NONE) begin
        if (req == REQ_RELEASE) begin
          // every slot holding the code is emptied
          foreach (held_keys[i]) if (held_keys[i] == code) held_keys[i] = CODE_NONE;
        end else begin
          // highest empty slot wins, slot 0 when the report is full
          foreach (held_keys[i]) begin
            if (held_keys[i] == code) already_held = 1'b1;
            else if (held_keys[i] == CODE_NONE) pick = i;
          end
          if (!already_held) held_keys[pick] = code;
        end
      end
      rep.modifier = mods;
      for (int j = 0; j < 6; j++) rep.slot[j] = (j < SLOT_COUNT) ? held_keys[j] : CODE_NONE;
      owed_reports.push_back(rep);
    endfunction

    // compare one report from the block with the oldest owed one
    function void check_report(kbd_report_t got);
      kbd_report_t want;
      if (owed_reports.size() == 0) begin
        $display("%0t: unexpected report, expected none, actual mod %h slots %h",
                 $time, got.modifier, got.slot);
        errors++;
        return;
      end
      want = owed_reports.pop_front();
      if (got.modifier !== want.modifier) begin
        $display("%0t: modifier_byte mismatch, expected %h actual %h",
                 $time, want.modifier, got.modifier);
        errors++;
      end
      for (int j = 0; j < 6; j++) begin
        if (got.slot[j] !== want.slot[j]) begin
          $display("%0t: key_slot_%0d mismatch, expected %h actual %h",
                   $time, j, want.slot[j], got.slot[j]);
          errors++;
        end
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_req_type;
  hkrt_code_t in_keycode;
  logic       out_strobe;
  hkrt_code_t out_modifier_byte;
  hkrt_code_t out_key_slot_0, out_key_slot_1, out_key_slot_2;
  hkrt_code_t out_key_slot_3, out_key_slot_4, out_key_slot_5;

  int idle_pct;
  report_scoreboard sb;

  hid_keyboard_report_tracker #(.SLOT_COUNT(SLOT_COUNT)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_keycode(in_keycode),
    .out_strobe(out_strobe), .out_modifier_byte(out_modifier_byte),
    .out_key_slot_0(out_key_slot_0), .out_key_slot_1(out_key_slot_1),
    .out_key_slot_2(out_key_slot_2), .out_key_slot_3(out_key_slot_3),
    .out_key_slot_4(out_key_slot_4), .out_key_slot_5(out_key_slot_5)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watch both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if (out_strobe === 1'b1) begin
        sb.check_report({out_modifier_byte, out_key_slot_5, out_key_slot_4, out_key_slot_3,
                         out_key_slot_2, out_key_slot_1, out_key_slot_0});
      end
      if (start === 1'b1 && busy === 1'b0) sb.note_event(in_req_type, in_keycode);
    end
  end

  // one key transfer; each cycle in front of it is idle with chance idle_pct
  task automatic send_key(input logic req, input hkrt_code_t code);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start       <= 1'b1;
    in_req_type <= req;
    in_keycode  <= code;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // mostly presses and releases over a small key set so slots fill and empty,
  // plus modifiers and some fully random noise
  task automatic send_random(input int count);
    int         roll;
    logic       req;
    hkrt_code_t code;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(0, 99);
      req  = 1'($urandom_range(0, 1));
      if (roll < 15) code = hkrt_code_t'(MOD_FIRST + $urandom_range(0, 7));
      else if (roll < 80) code = hkrt_code_t'(8'h04 + $urandom_range(0, 8));
      else code = hkrt_code_t'($urandom_range(0, 255));
      send_key(req, code);
    end
  endtask

  // timeout
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    sb          = new();
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req_type = REQ_PRESS;
    in_keycode  = CODE_NONE;
    idle_pct    = 0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    // modifiers at both ends of the range, code zero both ways
    send_key(REQ_PRESS, MOD_FIRST);
    send_key(REQ_PRESS, MOD_LAST);
    send_key(REQ_PRESS, 8'hE3);
    send_key(REQ_RELEASE, MOD_FIRST);
    send_key(REQ_PRESS, CODE_NONE);
    send_key(REQ_RELEASE, CODE_NONE);
    // fill all slots, with a repeated press in between
    send_key(REQ_PRESS, 8'h04);
    send_key(REQ_PRESS, 8'h05);
    send_key(REQ_PRESS, 8'h04);
    send_key(REQ_PRESS, 8'h06);
    send_key(REQ_PRESS, 8'h07);
    send_key(REQ_PRESS, 8'h08);
    send_key(REQ_PRESS, 8'h09);
    // full report overwrites slot 0
    send_key(REQ_PRESS, 8'hFF);
    send_key(REQ_PRESS, 8'hDF);
    // free one slot, refill it with a code just above the modifiers
    send_key(REQ_RELEASE, 8'h05);
    send_key(REQ_PRESS, 8'hE8);
    // release of a code not held, then release the modifiers and all keys but 8'h08
    send_key(REQ_RELEASE, 8'h77);
    send_key(REQ_RELEASE, MOD_LAST);
    send_key(REQ_RELEASE, 8'hE3);
    send_key(REQ_RELEASE, 8'hDF);
    send_key(REQ_RELEASE, 8'h04);
    send_key(REQ_RELEASE, 8'hE8);
    send_key(REQ_RELEASE, 8'h06);
    send_key(REQ_RELEASE, 8'h07);

    // random traffic: light gaps, heavy gaps, back to back
    idle_pct = 17;
    send_random(RANDOM_PER_PHASE);
    idle_pct = 78;
    send_random(RANDOM_PER_PHASE);
    idle_pct = 0;
    send_random(RANDOM_PER_PHASE);

    @(negedge clk);
    start <= 1'b0;

    // drain outstanding reports, then watch for strays
    while (sb.owed_reports.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.errors == 0 && sb.owed_reports.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/hkrt_pkg.sv
src/hkrt_report_update.sv
src/hid_keyboard_report_tracker.sv
dv/tb_hid_keyboard_report_tracker.sv
